// ===== design/deq_pkg.sv =====
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VALUE_W   = 32;
    localparam int ENTRY_W   = 7;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_WALK       = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [VALUE_W-1:0] push_value;
    } in_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] element_value;
        logic                      last_of_run;
        logic [ENTRY_W-1:0]        entry_count;
        logic [STATUS_W-1:0]       status;
    } out_word_t;

endpackage

// ===== design/double_ended_queue.sv =====
// double_ended_queue: bounded circular deque of signed 32-bit values in a ring memory
// input channel s_valid/s_ready/s_data carries one operation word: push front, push
// back, pop front, pop back or walk, with the value to push
// result channel m_valid/m_ready/m_data returns words with element value, last flag,
// entry count after the operation and status (done, full, empty)
// push and pop: one result word, registered, valid the cycle after the input word is
// taken; a new operation can be taken every cycle while results drain
// walk: the first element word goes through the memory read register, then the
// result register; after it one word per cycle while the result register is free,
// read from the ring memory, front to back; the input channel stays closed until
// the last element word is loaded; the single read port of the memory sets this rate
// push when full returns status full and stores nothing; pop or walk when empty
// returns one word with status empty; unknown operations return one done word
// reset (aresetn low, synchronous) empties the deque and drops any pending result;
// memory contents are not cleared and need no clearing pass
// when m_ready is low the result register holds its word and the input channel
// closes until the word is taken
`timescale 1ns / 1ps

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [IW-1:0]   front_reg, front_next;
    logic [CW-1:0]   walk_left_reg, walk_left_next;
    logic [IW-1:0]   walk_addr_reg, walk_addr_next;
    logic            m_valid_reg, m_valid_next;
    out_word_t       m_data_reg, m_data_next;

    logic               out_free;
    logic               is_full;
    logic               is_empty;
    logic [IW-1:0]      front_inc;
    logic [IW-1:0]      front_dec;
    logic [SW-1:0]      back_sum;
    logic [IW-1:0]      back_slot;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic [VALUE_W-1:0] rd_data;

    function automatic logic [IW-1:0] slot_inc(input logic [IW-1:0] s);
        return (s == IW'(DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    deq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_data.push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign front_inc = slot_inc(front_reg);
    assign front_dec = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - 1'b1;
    assign back_sum  = SW'(front_reg) + SW'(count_reg);
    assign back_slot = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        front_next     = front_reg;
        walk_left_next = walk_left_reg;
        walk_addr_next = walk_addr_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        wr_en          = 1'b0;
        wr_addr        = front_reg;
        rd_en          = 1'b0;
        rd_addr        = walk_addr_reg;
        s_ready        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.element_value = '0;
                    m_data_next.last_of_run   = 1'b1;
                    m_data_next.status        = STATUS_DONE;
                    case (s_data.operation)
                        OP_PUSH_FRONT: begin
                            if (is_full) begin
                                m_data_next.status = STATUS_FULL;
                            end else begin
                                front_next = front_dec;
                                wr_en      = 1'b1;
                                wr_addr    = front_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (is_full) begin
                                m_data_next.status = STATUS_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = back_slot;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (is_empty) begin
                                m_data_next.status = STATUS_EMPTY;
                            end else begin
                                front_next = front_inc;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_POP_BACK: begin
                            if (is_empty) begin
                                m_data_next.status = STATUS_EMPTY;
                            end else begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_WALK: begin
                            if (is_empty) begin
                                m_data_next.status = STATUS_EMPTY;
                            end else begin
                                m_valid_next   = 1'b0;
                                rd_en          = 1'b1;
                                rd_addr        = front_reg;
                                walk_addr_next = front_inc;
                                walk_left_next = count_reg;
                                state_next     = ST_WALK;
                            end
                        end
                        default: ;
                    endcase
                    m_data_next.entry_count = ENTRY_W'(count_next);
                end
            end
            ST_WALK: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.element_value = $signed(rd_data);
                    m_data_next.last_of_run   = (walk_left_reg == CW'(1));
                    m_data_next.entry_count   = ENTRY_W'(count_reg);
                    m_data_next.status        = STATUS_DONE;
                    walk_left_next            = walk_left_reg - 1'b1;
                    if (walk_left_reg == CW'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_en          = 1'b1;
                        rd_addr        = walk_addr_reg;
                        walk_addr_next = slot_inc(walk_addr_reg);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        m_data_reg     <= m_data_next;
        walk_left_reg  <= walk_left_next;
        walk_addr_reg  <= walk_addr_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            front_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            front_reg   <= front_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_front_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        SW'(front_reg) < SW'(DEPTH))
        else $error("front index outside ring");

    a_walk_left: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> (walk_left_reg != '0) && (walk_left_reg <= count_reg))
        else $error("walk remainder out of range");

    a_walk_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |=> (count_reg == $past(count_reg))
            && (front_reg == $past(front_reg)))
        else $error("deque changed during walk");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg.status == STATUS_FULL)
            |-> m_data_reg.entry_count == ENTRY_W'(DEPTH))
        else $error("full status with count below depth");
`endif

endmodule

// ===== design/deq_ram.sv =====
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== tb/sv/double_ended_queue_tb.sv =====
`timescale 1ns / 1ps

module double_ended_queue_tb;
    import deq_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;
    localparam int HOLD_CYCLES = 300;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    double_ended_queue uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    in_word_t  pending_ops[$];
    out_word_t due_words[$];

    // shadow of the ring memory and its pointers
    logic signed [VALUE_W-1:0] ring_copy [DEPTH_DEF];
    int ring_front = 0;
    int ring_count = 0;

    // occupancy as seen by the stimulus generator
    int gen_count = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_req  = 1'b0;
    bit   hold_used = 1'b0;
    int   hold_left = 0;
    int   errors    = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic out_word_t result_word(logic signed [VALUE_W-1:0] value, logic last,
                                              logic [STATUS_W-1:0] st);
        out_word_t w;
        w.element_value = value;
        w.last_of_run   = last;
        w.entry_count   = ENTRY_W'(ring_count);
        w.status        = st;
        return w;
    endfunction

    task automatic apply_deque_op(in_word_t op);
        int i;
        case (op.operation)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (ring_count >= DEPTH_DEF) begin
                    due_words.push_back(result_word('0, 1'b1, STATUS_FULL));
                end else begin
                    if (op.operation == OP_PUSH_FRONT) begin
                        ring_front = (ring_front + DEPTH_DEF - 1) % DEPTH_DEF;
                        ring_copy[ring_front] = op.push_value;
                    end else begin
                        ring_copy[(ring_front + ring_count) % DEPTH_DEF] = op.push_value;
                    end
                    ring_count++;
                    due_words.push_back(result_word('0, 1'b1, STATUS_DONE));
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (ring_count == 0) begin
                    due_words.push_back(result_word('0, 1'b1, STATUS_EMPTY));
                end else begin
                    if (op.operation == OP_POP_FRONT) begin
                        ring_front = (ring_front + 1) % DEPTH_DEF;
                    end
                    ring_count--;
                    due_words.push_back(result_word('0, 1'b1, STATUS_DONE));
                end
            end
            OP_WALK: begin
                if (ring_count == 0) begin
                    due_words.push_back(result_word('0, 1'b1, STATUS_EMPTY));
                end else begin
                    for (i = 0; i < ring_count; i++) begin
                        due_words.push_back(result_word(
                            ring_copy[(ring_front + i) % DEPTH_DEF],
                            (i == ring_count - 1), STATUS_DONE));
                    end
                end
            end
            default: begin
                due_words.push_back(result_word('0, 1'b1, STATUS_DONE));
            end
        endcase
    endtask

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    task automatic check_word(out_word_t got);
        out_word_t want;
        if (due_words.size() == 0) begin
            report_mismatch($sformatf("result word with none due: %p", got));
        end else begin
            want = due_words.pop_front();
            if (got.element_value !== want.element_value) begin
                report_mismatch($sformatf("element_value %0d, want %0d",
                                          got.element_value, want.element_value));
            end
            if (got.last_of_run !== want.last_of_run) begin
                report_mismatch($sformatf("last_of_run %b, want %b",
                                          got.last_of_run, want.last_of_run));
            end
            if (got.entry_count !== want.entry_count) begin
                report_mismatch($sformatf("entry_count %0d, want %0d",
                                          got.entry_count, want.entry_count));
            end
            if (got.status !== want.status) begin
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            end
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: begin
                return {1'b0, {(VALUE_W-1){1'b1}}};
            end
            1: begin
                return {1'b1, {(VALUE_W-1){1'b0}}};
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic queue_op(logic [OP_W-1:0] code, logic signed [VALUE_W-1:0] value);
        in_word_t w;
        w.operation  = code;
        w.push_value = value;
        pending_ops.push_back(w);
        if ((code == OP_PUSH_FRONT || code == OP_PUSH_BACK) && gen_count < DEPTH_DEF) begin
            gen_count++;
        end else if ((code == OP_POP_FRONT || code == OP_POP_BACK) && gen_count > 0) begin
            gen_count--;
        end
    endtask

    // bursts that mostly fill, mostly drain, mix, or throw any code
    task automatic queue_random(int total);
        int issued;
        int burst;
        int mode;
        int r;
        int k;
        logic [OP_W-1:0] code;
        issued = 0;
        while (issued < total) begin
            mode  = $urandom_range(99);
            burst = $urandom_range(40, 8);
            for (k = 0; k < burst && issued < total; k++) begin
                r = $urandom_range(99);
                if (r < 6) begin
                    code = OP_WALK;
                end else if (mode < 30) begin
                    code = (r < 88) ? OP_W'($urandom_range(OP_PUSH_BACK, OP_PUSH_FRONT))
                                    : OP_W'($urandom_range(OP_POP_BACK, OP_POP_FRONT));
                end else if (mode < 55) begin
                    code = (r < 88) ? OP_W'($urandom_range(OP_POP_BACK, OP_POP_FRONT))
                                    : OP_W'($urandom_range(OP_PUSH_BACK, OP_PUSH_FRONT));
                end else if (mode < 90) begin
                    code = OP_W'($urandom_range(OP_POP_BACK, OP_PUSH_FRONT));
                end else begin
                    code = OP_W'($urandom_range(OP_RESERVED_HI, OP_PUSH_FRONT));
                end
                queue_op(code, pick_value());
                issued++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || s_valid || due_words.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_deque_op(s_data);
            end
            if (!s_valid || s_ready) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_ops.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_req && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_word(m_data);
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty deque cases
        queue_op(OP_POP_FRONT, '0);
        queue_op(OP_POP_BACK, '0);
        queue_op(OP_WALK, '0);
        queue_op(OP_RESERVED_LO, '0);
        queue_op(OP_RESERVED_LO + 3'd1, '0);
        queue_op(OP_RESERVED_HI, '1);
        // extreme values at both ends
        queue_op(OP_PUSH_BACK, {1'b0, {(VALUE_W-1){1'b1}}});
        queue_op(OP_PUSH_FRONT, {1'b1, {(VALUE_W-1){1'b0}}});
        queue_op(OP_PUSH_BACK, '0);
        queue_op(OP_PUSH_FRONT, '1);
        queue_op(OP_PUSH_BACK, {(VALUE_W/2){2'b01}});
        queue_op(OP_PUSH_FRONT, {(VALUE_W/2){2'b10}});
        queue_op(OP_WALK, '0);
        queue_op(OP_POP_FRONT, '0);
        queue_op(OP_POP_BACK, '0);
        queue_op(OP_WALK, '0);
        queue_op(OP_RESERVED_HI, {(VALUE_W/2){2'b10}});
        queue_op(OP_POP_FRONT, '0);
        queue_op(OP_POP_BACK, '0);
        queue_op(OP_POP_FRONT, '0);
        queue_op(OP_POP_BACK, '0);
        queue_op(OP_WALK, '0);
        queue_random(70);
        wait_drained();

        send_idle_pct = 87;
        queue_random(70);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 87;
        queue_random(70);
        wait_drained();

        send_idle_pct  = 26;
        recv_stall_pct = 26;
        queue_random(70);
        wait_drained();

        // fill past full under a long receiver hold, walk, then drain past empty
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        while (gen_count < DEPTH_DEF) begin
            queue_op(OP_W'($urandom_range(OP_PUSH_BACK, OP_PUSH_FRONT)), pick_value());
        end
        queue_op(OP_PUSH_FRONT, pick_value());
        queue_op(OP_PUSH_BACK, pick_value());
        queue_op(OP_PUSH_FRONT, pick_value());
        queue_op(OP_PUSH_BACK, pick_value());
        queue_op(OP_WALK, '0);
        while (gen_count > 0) begin
            queue_op(OP_W'($urandom_range(OP_POP_BACK, OP_POP_FRONT)), '0);
        end
        queue_op(OP_POP_FRONT, '0);
        queue_op(OP_POP_BACK, '0);
        queue_op(OP_WALK, '0);
        wait_drained();

        repeat (20) @(negedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
